>>> sv/cgsp_pkg.sv
package cgsp_pkg;

  // default store sizes
  localparam int MAX_LENGTH_DEF = 16;
  localparam int MAX_BASIS_DEF  = 8;

  // configuration register indexes
  localparam logic CFG_VECTOR_LENGTH = 1'b0;
  localparam logic CFG_BASIS_COUNT   = 1'b1;

  // request kinds on the slave side
  localparam logic OP_BASIS = 1'b0;
  localparam logic OP_INPUT = 1'b1;

  // result kinds on the master side
  localparam logic [1:0] KIND_RESIDUAL = 2'd0;
  localparam logic [1:0] KIND_COEF     = 2'd1;
  localparam logic [1:0] KIND_NORM     = 2'd2;

  localparam logic [4:0] VECTOR_LENGTH_RST = 5'd16;
  localparam logic [3:0] BASIS_COUNT_RST   = 4'd0;

  // round a q48 product to q24, half up
  function automatic logic signed [39:0] qround(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sh0000_0000_0080_0000;
    return $signed(t[63:24]);
  endfunction

  // saturate to a signed 32 bit word
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> sv/complex_gram_schmidt_projector_unit.sv
// channel   dir  handshake                 payload
// s_axis    in   tvalid/tready             tdata: basis_index, element_index, re, im
//                                          tuser: operation, tlast: final_element
// m_axis    out  tvalid/tready             tdata: result_index, re, im
//                                          tuser: result_kind, tlast: result_last
// cfg       in   cfg_we_i (no wait)        cfg_addr_i, cfg_wdata_i
//
// a load request is written straight into its store; the final input element starts a run
// of P = 1 or 2 passes (with no basis vectors the pass term is just the check state), all
// paced by the one shared 32x32 multiplier, the bit-serial square root and the bit-serial
// divider (real and imaginary parts in turn)
// a tiny residual skips root and divider and is written back as zero
// reset is asynchronous, active low; the stores need no clearing
// s_axis_tready_o is low during a run; results stall in the output register
module complex_gram_schmidt_projector_unit
  import cgsp_pkg::*;
#(
  parameter int MAX_LENGTH = MAX_LENGTH_DEF,
  parameter int MAX_BASIS  = MAX_BASIS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // basis_index [2:0], element_index [6:3], value_re [38:7], value_im [70:39]
  input  logic [71:0] s_axis_tdata_i,
  // operation
  input  logic        s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // result_index [3:0], result_re [35:4], result_im [67:36]
  output logic [71:0] m_axis_tdata_o,
  // result_kind
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [4:0]  cfg_wdata_i
);

  localparam int LW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int KW    = $clog2(MAX_LENGTH + 1);
  localparam int BI    = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
  localparam int BW    = $clog2(MAX_BASIS + 1);
  localparam int DEPTH = MAX_BASIS * MAX_LENGTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // sequencer states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_NORM      = 4'd1;
  localparam logic [3:0] S_DOT       = 4'd2;
  localparam logic [3:0] S_COEF      = 4'd3;
  localparam logic [3:0] S_UPD       = 4'd4;
  localparam logic [3:0] S_CHECK     = 4'd5;
  localparam logic [3:0] S_SQRT      = 4'd6;
  localparam logic [3:0] S_DIV       = 4'd7;
  localparam logic [3:0] S_EMIT_RES  = 4'd8;
  localparam logic [3:0] S_EMIT_COEF = 4'd9;
  localparam logic [3:0] S_EMIT_NORM = 4'd10;

  // input request fields
  logic [2:0]         in_bidx;
  logic [3:0]         in_eidx;
  logic signed [31:0] in_re, in_im;
  logic               in_acc;

  assign in_bidx = s_axis_tdata_i[2:0];
  assign in_eidx = s_axis_tdata_i[6:3];
  assign in_re   = s_axis_tdata_i[38:7];
  assign in_im   = s_axis_tdata_i[70:39];
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;

  // configuration
  logic [4:0] vl_q;
  logic [3:0] bc_q;
  logic [KW-1:0] len_w;
  logic [BW-1:0] nb_w;

  // sequencer and datapath registers
  logic [3:0]          state_q;
  logic [KW-1:0]       k_q;
  logic [BW-1:0]       i_q;
  logic [2:0]          sub_q;
  logic                pass_q, proj_q, tiny_q, part_q;
  logic [63:0]         acc_q, init_q;
  logic signed [47:0]  sr_q, si_q, tr_q, ti_q;
  logic signed [63:0]  prod_q;
  logic signed [31:0]  cr_q, ci_q, qre_q;
  logic [63:0]         sq_v_q, sq_r_q, sq_b_q;
  logic [31:0]         nrm_q;
  logic [55:0]         num_q, quo_q;
  logic [31:0]         rem_q;
  logic [5:0]          cnt_q;
  logic                neg_q;

  // stores
  logic [63:0] basis_mem [DEPTH];
  logic [63:0] bv_q;
  logic [63:0] wv_q [MAX_LENGTH];
  logic signed [31:0] cf_re_q [MAX_BASIS];
  logic signed [31:0] cf_im_q [MAX_BASIS];

  // output register
  logic        out_valid_q;
  logic [71:0] out_data_q;
  logic [1:0]  out_kind_q;
  logic        out_last_q;
  logic        out_free;
  logic        out_load;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign out_load        = out_free && ((state_q == S_EMIT_RES) ||
                           (state_q == S_EMIT_COEF) || (state_q == S_EMIT_NORM));

  // effective length and basis count
  always_comb begin
    if (vl_q == 5'd0) begin
      len_w = KW'(1);
    end else if (int'(vl_q) > MAX_LENGTH) begin
      len_w = KW'(MAX_LENGTH);
    end else begin
      len_w = KW'(vl_q);
    end
    if (int'(bc_q) > MAX_BASIS) begin
      nb_w = BW'(MAX_BASIS);
    end else begin
      nb_w = BW'(bc_q);
    end
  end

  logic [LW-1:0]      kx;
  logic [BI-1:0]      ix;
  logic signed [31:0] x_re, x_im, v_re, v_im;
  logic               last_k, last_i;
  logic [AW-1:0]      rd_addr;

  assign kx      = k_q[LW-1:0];
  assign ix      = i_q[BI-1:0];
  assign x_re    = wv_q[kx][31:0];
  assign x_im    = wv_q[kx][63:32];
  assign v_re    = bv_q[31:0];
  assign v_im    = bv_q[63:32];
  assign last_k  = (k_q + KW'(1)) == len_w;
  assign last_i  = (i_q + BW'(1)) == nb_w;
  assign rd_addr = AW'(int'(i_q) * MAX_LENGTH + int'(k_q));

  // the shared multiplier, operands chosen by the sequencer step
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod_d;
  logic signed [39:0] rnd_w;

  always_comb begin
    ma = x_re;
    mb = x_re;
    case (state_q)
      S_NORM: begin
        if (sub_q != 3'd0) begin
          ma = x_im;
          mb = x_im;
        end
      end
      S_DOT: begin
        case (sub_q)
          3'd2:    begin ma = v_im; mb = x_im; end
          3'd3:    begin ma = v_re; mb = x_im; end
          3'd4:    begin ma = v_im; mb = x_re; end
          default: begin ma = v_re; mb = x_re; end
        endcase
      end
      S_UPD: begin
        case (sub_q)
          3'd2:    begin ma = ci_q; mb = v_im; end
          3'd3:    begin ma = cr_q; mb = v_im; end
          3'd4:    begin ma = ci_q; mb = v_re; end
          default: begin ma = cr_q; mb = v_re; end
        endcase
      end
      default: ;
    endcase
    prod_d = ma * mb;
  end

  assign rnd_w = qround(prod_q);

  // saturating accumulation of squares
  logic [64:0] acc_sum;
  logic [63:0] acc_d;
  assign acc_sum = {1'b0, acc_q} + {1'b0, prod_q};
  assign acc_d   = acc_sum[64] ? '1 : acc_sum[63:0];

  // square root step
  logic [63:0] sq_t, sq_r_d;
  logic        sq_ge;
  assign sq_t   = sq_r_q + sq_b_q;
  assign sq_ge  = sq_v_q >= sq_t;
  assign sq_r_d = sq_ge ? ((sq_r_q >> 1) + sq_b_q) : (sq_r_q >> 1);

  // divider step and setup
  logic [32:0]        rem_sh;
  logic               dv_ge;
  logic signed [31:0] dx;
  logic [32:0]        dmag;
  logic               dbig;
  logic signed [31:0] dres;

  assign rem_sh = {rem_q, num_q[55]};
  assign dv_ge  = rem_sh >= {1'b0, nrm_q};
  assign dx     = part_q ? x_im : x_re;
  assign dmag   = dx[31] ? -{dx[31], dx} : {dx[31], dx};
  assign dbig   = quo_q[55:31] != '0;

  always_comb begin
    if (neg_q) begin
      dres = dbig ? 32'sh8000_0000 : -$signed(quo_q[31:0]);
    end else begin
      dres = dbig ? 32'sh7FFF_FFFF : $signed(quo_q[31:0]);
    end
  end

  logic signed [31:0] cr_w, ci_w;
  assign cr_w = sat32(sr_q);
  assign ci_w = sat32(si_q);

  // work vector write port
  logic          wv_we;
  logic [LW-1:0] wv_addr;
  logic [63:0]   wv_wdata;

  always_comb begin
    wv_we    = 1'b0;
    wv_addr  = kx;
    wv_wdata = '0;
    if (state_q == S_IDLE) begin
      wv_addr  = LW'(in_eidx);
      wv_wdata = {in_im, in_re};
      wv_we    = in_acc && (s_axis_tuser_i == OP_INPUT) && (int'(in_eidx) < MAX_LENGTH);
    end else if (state_q == S_UPD) begin
      wv_wdata = {sat32(48'(x_im) - ti_q), sat32(48'(x_re) - tr_q)};
      wv_we    = (sub_q == 3'd6);
    end else if (state_q == S_DIV) begin
      if (tiny_q) begin
        wv_we = 1'b1;
      end else begin
        wv_wdata = {dres, qre_q};
        wv_we    = (sub_q == 3'd2) && part_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wv_we) begin
      wv_q[wv_addr] <= wv_wdata;
    end
  end

  // basis memory, one write port in idle, registered read during a run
  always_ff @(posedge clk_i) begin
    if (in_acc && (s_axis_tuser_i == OP_BASIS) && (int'(in_bidx) < MAX_BASIS) &&
        (int'(in_eidx) < MAX_LENGTH)) begin
      basis_mem[AW'(int'(in_bidx) * MAX_LENGTH + int'(in_eidx))] <= {in_im, in_re};
    end
    bv_q <= basis_mem[rd_addr];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q <= VECTOR_LENGTH_RST;
      bc_q <= BASIS_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_VECTOR_LENGTH: vl_q <= cfg_wdata_i;
        CFG_BASIS_COUNT:   bc_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      i_q         <= '0;
      sub_q       <= '0;
      pass_q      <= 1'b0;
      proj_q      <= 1'b0;
      tiny_q      <= 1'b0;
      part_q      <= 1'b0;
      acc_q       <= '0;
      init_q      <= '0;
      sr_q        <= '0;
      si_q        <= '0;
      tr_q        <= '0;
      ti_q        <= '0;
      prod_q      <= '0;
      cr_q        <= '0;
      ci_q        <= '0;
      qre_q       <= '0;
      sq_v_q      <= '0;
      sq_r_q      <= '0;
      sq_b_q      <= '0;
      nrm_q       <= '0;
      num_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_kind_q  <= KIND_RESIDUAL;
      out_last_q  <= 1'b0;
      for (int b = 0; b < MAX_BASIS; b++) begin
        cf_re_q[b] <= '0;
        cf_im_q[b] <= '0;
      end
    end else begin
      prod_q <= prod_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && (s_axis_tuser_i == OP_INPUT) && s_axis_tlast_i) begin
            state_q <= S_NORM;
            k_q     <= '0;
            sub_q   <= '0;
            acc_q   <= '0;
            pass_q  <= 1'b0;
            proj_q  <= 1'b0;
            tiny_q  <= 1'b0;
          end
        end
        S_NORM: begin
          if (sub_q == 3'd0) begin
            sub_q <= 3'd1;
          end else if (sub_q == 3'd1) begin
            acc_q <= acc_d;
            sub_q <= 3'd2;
          end else begin
            acc_q <= acc_d;
            sub_q <= '0;
            if (!last_k) begin
              k_q <= k_q + KW'(1);
            end else begin
              k_q <= '0;
              if (proj_q) begin
                state_q <= S_CHECK;
              end else begin
                init_q <= acc_d;
                proj_q <= 1'b1;
                if (nb_w == '0) begin
                  state_q <= S_CHECK;
                end else begin
                  state_q <= S_DOT;
                  i_q     <= '0;
                  sr_q    <= '0;
                  si_q    <= '0;
                end
              end
            end
          end
        end
        S_DOT: begin
          if (sub_q != 3'd5) begin
            sub_q <= sub_q + 3'd1;
          end
          case (sub_q)
            3'd2: sr_q <= sr_q + 48'(rnd_w);
            3'd3: sr_q <= sr_q + 48'(rnd_w);
            3'd4: si_q <= si_q + 48'(rnd_w);
            3'd5: begin
              si_q  <= si_q - 48'(rnd_w);
              sub_q <= '0;
              if (last_k) begin
                k_q     <= '0;
                state_q <= S_COEF;
              end else begin
                k_q <= k_q + KW'(1);
              end
            end
            default: ;
          endcase
        end
        S_COEF: begin
          cr_q <= cr_w;
          ci_q <= ci_w;
          if (pass_q) begin
            cf_re_q[ix] <= sat32(48'(cf_re_q[ix]) + 48'(cr_w));
            cf_im_q[ix] <= sat32(48'(cf_im_q[ix]) + 48'(ci_w));
          end else begin
            cf_re_q[ix] <= cr_w;
            cf_im_q[ix] <= ci_w;
          end
          sub_q   <= '0;
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (sub_q != 3'd6) begin
            sub_q <= sub_q + 3'd1;
          end
          case (sub_q)
            3'd0: begin
              tr_q <= '0;
              ti_q <= '0;
            end
            3'd2: tr_q <= tr_q + 48'(rnd_w);
            3'd3: tr_q <= tr_q - 48'(rnd_w);
            3'd4: ti_q <= ti_q + 48'(rnd_w);
            3'd5: ti_q <= ti_q + 48'(rnd_w);
            3'd6: begin
              sub_q <= '0;
              if (!last_k) begin
                k_q <= k_q + KW'(1);
              end else begin
                k_q <= '0;
                if (last_i) begin
                  i_q     <= '0;
                  acc_q   <= '0;
                  state_q <= S_NORM;
                end else begin
                  i_q     <= i_q + BW'(1);
                  sr_q    <= '0;
                  si_q    <= '0;
                  state_q <= S_DOT;
                end
              end
            end
            default: ;
          endcase
        end
        S_CHECK: begin
          k_q    <= '0;
          sub_q  <= '0;
          part_q <= 1'b0;
          if (!pass_q && (acc_q[63:62] == 2'b00) && ({acc_q[61:0], 2'b00} < init_q)) begin
            // residual lost more than half its norm: second pass
            pass_q  <= 1'b1;
            i_q     <= '0;
            sr_q    <= '0;
            si_q    <= '0;
            state_q <= S_DOT;
          end else if (acc_q[63:24] == '0) begin
            tiny_q  <= 1'b1;
            nrm_q   <= '0;
            state_q <= S_DIV;
          end else begin
            sq_v_q  <= acc_q;
            sq_r_q  <= '0;
            sq_b_q  <= 64'h4000_0000_0000_0000;
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_v_q <= sq_v_q - sq_t;
          end
          sq_r_q <= sq_r_d;
          sq_b_q <= sq_b_q >> 2;
          if (sq_b_q == 64'd1) begin
            nrm_q   <= sq_r_d[31:0];
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (tiny_q) begin
            if (last_k) begin
              k_q     <= '0;
              state_q <= S_EMIT_RES;
            end else begin
              k_q <= k_q + KW'(1);
            end
          end else if (sub_q == 3'd0) begin
            num_q <= {dmag[31:0], 24'd0} + 56'(nrm_q >> 1);
            rem_q <= '0;
            quo_q <= '0;
            neg_q <= dx[31];
            cnt_q <= 6'd55;
            sub_q <= 3'd1;
          end else if (sub_q == 3'd1) begin
            rem_q <= dv_ge ? 32'(rem_sh - {1'b0, nrm_q}) : rem_sh[31:0];
            quo_q <= {quo_q[54:0], dv_ge};
            num_q <= {num_q[54:0], 1'b0};
            cnt_q <= cnt_q - 6'd1;
            if (cnt_q == 6'd0) begin
              sub_q <= 3'd2;
            end
          end else begin
            sub_q <= '0;
            if (!part_q) begin
              qre_q  <= dres;
              part_q <= 1'b1;
            end else begin
              part_q <= 1'b0;
              if (last_k) begin
                k_q     <= '0;
                state_q <= S_EMIT_RES;
              end else begin
                k_q <= k_q + KW'(1);
              end
            end
          end
        end
        S_EMIT_RES: begin
          if (out_free) begin
            out_data_q  <= {4'd0, x_im, x_re, 4'(k_q)};
            out_kind_q  <= KIND_RESIDUAL;
            out_last_q  <= 1'b0;
            if (last_k) begin
              k_q     <= '0;
              i_q     <= '0;
              state_q <= (nb_w == '0) ? S_EMIT_NORM : S_EMIT_COEF;
            end else begin
              k_q <= k_q + KW'(1);
            end
          end
        end
        S_EMIT_COEF: begin
          if (out_free) begin
            out_data_q  <= {4'd0, cf_im_q[ix], cf_re_q[ix], 4'(i_q)};
            out_kind_q  <= KIND_COEF;
            out_last_q  <= 1'b0;
            if (last_i) begin
              i_q     <= '0;
              state_q <= S_EMIT_NORM;
            end else begin
              i_q <= i_q + BW'(1);
            end
          end
        end
        S_EMIT_NORM: begin
          if (out_free) begin
            out_data_q  <= {4'd0, 32'd0, (nrm_q[31] ? 32'h7FFF_FFFF : nrm_q), 4'd0};
            out_kind_q  <= KIND_NORM;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // only the norm result closes a run
  a_last_is_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tuser_o == KIND_NORM))
    else $error("tlast on a result that is not the norm");

  // a norm that reaches the divider is at least 4096 (a bit at 12 or above is set)
  a_div_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && !tiny_q) |-> (nrm_q[31:12] != '0))
    else $error("divider started with a norm below range");

  // the element counter stays inside the vector in use
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q < len_w)
    else $error("element counter beyond vector length");
`endif

endmodule
